// File: sv/euclidean_norm_float_stream_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the streaming Euclidean norm block
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef EUCLIDEAN_NORM_FLOAT_STREAM_DEFINES_SVH
`define EUCLIDEAN_NORM_FLOAT_STREAM_DEFINES_SVH

// implication checked each clock, disabled in reset
`define ENF_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// next-cycle implication
`define ENF_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

// File: sv/enf_pkg.sv
// ----------------------------------------------------------------------------
// enf_pkg
// Types and constants for the streaming Euclidean norm block.
// ----------------------------------------------------------------------------
package enf_pkg;
    localparam int unsigned DATA_W = 32;
    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [31:0] PINF_BITS = 32'h7F80_0000;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_ALIGN, ST_ADD, ST_NORM, ST_RND,
        ST_SQRT_PREP, ST_SQRT_ITER, ST_SQRT_NORM, ST_SQRT_RND, ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic sq;
        logic align;
        logic add;
        logic norm;
        logic rnd;
        logic sqrt_prep;
        logic sqrt_iter;
        logic sqrt_norm;
        logic sqrt_rnd;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic fma_bypass;
        logic sqrt_bypass;
        logic sqrt_done;
    } t_status;

    // pack m * 2^e (m nonzero, lead bit at most 63) to a positive binary32
    function automatic logic [31:0] pack_pos(input logic [63:0] m,
                                             input logic signed [11:0] e,
                                             input logic [5:0] p);
        logic signed [11:0] lsb;
        logic signed [11:0] s;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] half;
        logic [63:0] bits;
        lsb = 12'(p) + e - 12'sd23;
        if (lsb < -12'sd149) lsb = -12'sd149;
        s = lsb - e;
        q = 64'd0;
        r = 64'd0;
        half = 64'd0;
        if (lsb + 12'sd150 > 12'sd254) begin
            pack_pos = PINF_BITS;
        end else begin
            if (s <= 0) begin
                q = m << 6'(-s);
            end else if (s > 12'sd64) begin
                q = 64'd0;
            end else begin
                if (s == 12'sd64) begin
                    q = 64'd0;
                    r = m;
                end else begin
                    q = m >> 6'(s);
                    r = m & ((64'd1 << 6'(s)) - 64'd1);
                end
                half = 64'd1 << 6'(s - 12'sd1);
                if (r > half || (r == half && q[0])) q = q + 64'd1;
            end
            bits = (64'(lsb + 12'sd149) << 23) + q;
            pack_pos = (bits >= 64'(PINF_BITS)) ? PINF_BITS : bits[31:0];
        end
    endfunction
endpackage

// File: sv/enf_ctrl.sv
// ----------------------------------------------------------------------------
// enf_ctrl
// Sequencer for accumulate and square-root steps, with handshakes.
// ----------------------------------------------------------------------------
module enf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_has_element,
    input  logic             i_last_flag,
    output logic             o_valid,
    input  logic             i_ready,
    input  enf_pkg::t_status i_status,
    output enf_pkg::t_cmd    o_cmd
);
    import enf_pkg::*;

    t_state r_state, n_state;
    logic   r_last, n_last;
    logic   accept;

    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_last = i_last_flag;
                    if (i_has_element) n_state = ST_SQ;
                    else if (i_last_flag) n_state = ST_SQRT_PREP;
                end
            end
            ST_SQ: begin
                o_cmd.sq = 1'b1;
                n_state = ST_ALIGN;
            end
            ST_ALIGN: begin
                o_cmd.align = 1'b1;
                n_state = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.add = 1'b1;
                n_state = ST_NORM;
            end
            ST_NORM: begin
                o_cmd.norm = 1'b1;
                n_state = ST_RND;
            end
            ST_RND: begin
                o_cmd.rnd = 1'b1;
                n_state = r_last ? ST_SQRT_PREP : ST_IDLE;
            end
            ST_SQRT_PREP: begin
                o_cmd.sqrt_prep = 1'b1;
                n_state = ST_SQRT_ITER;
            end
            ST_SQRT_ITER: begin
                if (i_status.sqrt_done) n_state = ST_SQRT_NORM;
                else o_cmd.sqrt_iter = 1'b1;
            end
            ST_SQRT_NORM: begin
                o_cmd.sqrt_norm = 1'b1;
                n_state = ST_SQRT_RND;
            end
            ST_SQRT_RND: begin
                o_cmd.sqrt_rnd = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    o_cmd.clear = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// File: sv/enf_dp.sv
// ----------------------------------------------------------------------------
// enf_dp
// Datapath: staged fused square-accumulate and bit-pair square root.
// ----------------------------------------------------------------------------
module enf_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [31:0]            i_element_bits,
    input  enf_pkg::t_cmd          i_cmd,
    output enf_pkg::t_status       o_status,
    output logic [31:0]            o_norm_bits
);
    import enf_pkg::*;

    logic [31:0]        r_sum;
    logic [31:0]        r_x;
    logic [31:0]        r_norm;
    logic [63:0]        r_pm, r_am, r_acc;
    logic signed [11:0] r_pe, r_ae, r_e;
    logic [5:0]         r_lp;
    logic               r_byp;
    logic [31:0]        r_byp_val;
    // square root
    logic [63:0]        r_m, r_res, r_bit;
    logic signed [11:0] r_se;

    logic [30:0] xa, aa;
    logic [23:0] xm, amn;
    logic signed [11:0] xe, ae0;

    assign xa  = r_x[30:0];
    assign aa  = r_sum[30:0];
    assign xm  = (xa[30:23] == 8'd0) ? {1'b0, xa[22:0]} : {1'b1, xa[22:0]};
    assign xe  = (xa[30:23] == 8'd0) ? -12'sd149 : 12'(xa[30:23]) - 12'sd150;
    assign amn = (aa[30:23] == 8'd0) ? {1'b0, aa[22:0]} : {1'b1, aa[22:0]};
    assign ae0 = (aa[30:23] == 8'd0) ? -12'sd149 : 12'(aa[30:23]) - 12'sd150;

    function automatic logic [5:0] lead(input logic [63:0] v);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 64; i++) if (v[i]) p = 6'(i);
        return p;
    endfunction

    logic [5:0] pl, al;
    logic [63:0] sq;
    assign sq = 64'(xm) * 64'(xm);
    assign pl = lead(r_pm);
    assign al = lead(r_am);

    logic signed [11:0] pe_n, ae_n, d;
    logic [63:0] pm_n, am_n, small_m, sticky_m;
    assign pm_n = r_pm << (6'd61 - pl);
    assign pe_n = r_pe - 12'(6'd61 - pl);
    assign am_n = r_am << (6'd61 - al);
    assign ae_n = r_ae - 12'(6'd61 - al);
    assign d    = (r_pe >= r_ae) ? r_pe - r_ae : r_ae - r_pe;
    assign small_m = (r_pe >= r_ae) ? r_am : r_pm;
    always_comb begin
        if (d <= 0) sticky_m = small_m;
        else if (d >= 12'sd63) sticky_m = 64'(small_m != 0);
        else sticky_m = (small_m >> 6'(d)) |
                        64'((small_m & ((64'd1 << 6'(d)) - 64'd1)) != 0);
    end

    // square-root step
    logic [63:0] trial;
    assign trial = r_res + r_bit;

    // prep values
    logic [23:0] sm0;
    logic signed [11:0] se0;
    logic [63:0] sm1;
    logic signed [11:0] se1;
    assign sm0 = (r_sum[30:23] == 8'd0) ? {1'b0, r_sum[22:0]} : {1'b1, r_sum[22:0]};
    assign se0 = (r_sum[30:23] == 8'd0) ? -12'sd149 : 12'(r_sum[30:23]) - 12'sd150;
    assign sm1 = se0[0] ? 64'(sm0) << 1 : 64'(sm0);
    assign se1 = se0[0] ? se0 - 12'sd1 : se0;
    logic [5:0] sl, k;
    assign sl = lead(sm1);
    assign k  = (6'd61 - sl) & 6'h3E;

    assign o_status.fma_bypass  = r_byp;
    assign o_status.sqrt_bypass = r_byp;
    assign o_status.sqrt_done   = (r_bit == 64'd0);
    assign o_norm_bits = r_norm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= 32'd0;
        end else begin
            if (i_cmd.rnd) r_sum <= r_byp ? r_byp_val : pack_pos(r_acc, r_e, r_lp);
            if (i_cmd.clear) r_sum <= 32'd0;
        end
        if (i_cmd.load) r_x <= i_element_bits;
        if (i_cmd.sq) begin
            r_pm <= sq;
            r_pe <= xe <<< 1;
            r_am <= 64'(amn);
            r_ae <= ae0;
            r_byp <= 1'b1;
            if (xa > 31'(PINF_BITS) || aa > 31'(PINF_BITS)) r_byp_val <= QNAN_BITS;
            else if (xa == 31'(PINF_BITS) || aa == 31'(PINF_BITS)) r_byp_val <= PINF_BITS;
            else if (xm == 24'd0) r_byp_val <= {1'b0, aa};
            else r_byp <= 1'b0;
        end
        if (i_cmd.align) begin
            r_pm <= pm_n;
            r_pe <= pe_n;
            if (r_am != 0) begin
                r_am <= am_n;
                r_ae <= ae_n;
            end
        end
        if (i_cmd.add) begin
            if (r_am == 0) begin
                r_acc <= r_pm;
                r_e   <= r_pe;
            end else if (r_pe >= r_ae) begin
                r_acc <= r_pm + sticky_m;
                r_e   <= r_pe;
            end else begin
                r_acc <= r_am + sticky_m;
                r_e   <= r_ae;
            end
        end
        if (i_cmd.norm) r_lp <= lead(r_acc);
        if (i_cmd.sqrt_prep) begin
            r_byp <= 1'b1;
            if (r_sum[30:0] > 31'(PINF_BITS)) r_byp_val <= QNAN_BITS;
            else if (r_sum[30:0] == 31'd0) r_byp_val <= r_sum;
            else if (r_sum[31]) r_byp_val <= QNAN_BITS;
            else if (r_sum == PINF_BITS) r_byp_val <= PINF_BITS;
            else r_byp <= 1'b0;
            r_m   <= sm1 << k;
            r_se  <= se1 - 12'(k);
            r_res <= 64'd0;
            r_bit <= 64'd1 << 62;
        end
        if (i_cmd.sqrt_iter) begin
            if (r_bit > r_m && r_res == 64'd0) begin
                r_bit <= r_bit >> 2;
            end else begin
                if (r_m >= trial) begin
                    r_m   <= r_m - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
        end
        if (i_cmd.sqrt_norm) begin
            r_acc <= (r_res << 1) | 64'(r_m != 0);
            r_e   <= (r_se >>> 1) - 12'sd1;
            r_lp  <= lead((r_res << 1) | 64'(r_m != 0));
        end
        if (i_cmd.sqrt_rnd) r_norm <= r_byp ? r_byp_val : pack_pos(r_acc, r_e, r_lp);
    end
endmodule

// File: sv/euclidean_norm_float_stream.sv
// Element item: registered steps square, align, add, normalise and round; end of vector adds the square root.
// Elements: a new element is taken only once the staged square-accumulate loop has rounded the last one.
// Square root: bit-pair method over a 64-bit radicand, up to 32 steps.
// Reset: synchronous active-low; sum cleared to +0.0, no result pending.
// ----------------------------------------------------------------------------
// euclidean_norm_float_stream
// Streaming binary32 Euclidean norm: sum of squares, then square root.
// ----------------------------------------------------------------------------
module euclidean_norm_float_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_element_bits,
    input  logic        i_has_element,
    input  logic        i_last_flag,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_norm_bits
);
    import enf_pkg::*;

    t_cmd    cmd;
    t_status status;

    enf_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_has_element, .i_last_flag,
        .o_valid, .i_ready, .i_status(status), .o_cmd(cmd)
    );

    enf_dp u_dp (
        .i_clk, .i_rst_n, .i_element_bits, .i_cmd(cmd), .o_status(status),
        .o_norm_bits
    );
endmodule

// File: sv/enf_checker.sv
// ----------------------------------------------------------------------------
// enf_checker
// Port-level checks for the streaming Euclidean norm block.
// ----------------------------------------------------------------------------
`include "euclidean_norm_float_stream_defines.svh"
module enf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_norm_bits
);
    `ENF_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_norm_bits))
    `ENF_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, o_valid, !o_ready)
    `ENF_ASSERT_NXT(a_out_drop, i_clk, i_rst_n, o_valid && i_ready, !o_valid)
endmodule

bind euclidean_norm_float_stream enf_checker u_chk (
    .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready, .o_norm_bits
);

// File: tb/norm_checker.sv
// ----------------------------------------------------------------------------
// norm_checker
// Watches the element and norm channels, keeps its own binary32 sum of squares
// rounded after each element, and compares each norm transfer in order.
// ----------------------------------------------------------------------------
module norm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [31:0] i_element_bits,
    input  logic        i_has_element,
    input  logic        i_last_flag,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_norm_bits,
    output int          o_errors,
    output int          o_pending,
    output int          o_norms
);
    timeunit 1ns;
    timeprecision 1ps;
    import enf_pkg::*;

    logic [31:0] acc_sum;
    logic [31:0] norm_queue[$];

    function automatic int top_bit(input logic [63:0] m);
        int p;
        p = 63;
        while (p > 0 && !m[p]) p--;
        return p;
    endfunction

    function automatic logic [31:0] round_pos(input logic [63:0] m, input int e);
        int p;
        int lsb;
        int s;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] half;
        logic [63:0] bits;
        p = top_bit(m);
        lsb = p + e - 23;
        if (lsb < -149) lsb = -149;
        if (lsb + 150 > 254) return PINF_BITS;
        s = lsb - e;
        if (s <= 0) begin
            q = m << (-s);
        end else if (s > 64) begin
            q = 0;
        end else begin
            if (s == 64) begin
                q = 0;
                r = m;
            end else begin
                q = m >> s;
                r = m & ((64'd1 << s) - 1);
            end
            half = 64'd1 << (s - 1);
            if (r > half || (r == half && q[0])) q = q + 1;
        end
        bits = (64'(lsb + 149) << 23) + q;
        if (bits >= 64'(PINF_BITS)) return PINF_BITS;
        return bits[31:0];
    endfunction

    function automatic logic [63:0] sticky_shift(input logic [63:0] m, input int d);
        if (d <= 0) return m;
        if (d >= 63) return 64'(m != 0);
        return (m >> d) | 64'((m & ((64'd1 << d) - 1)) != 0);
    endfunction

    function automatic void split_mag(input logic [31:0] a, output logic [63:0] m,
                                      output int e);
        if (a[30:23] == 0) begin
            m = 64'(a[22:0]);
            e = -149;
        end else begin
            m = 64'({1'b1, a[22:0]});
            e = int'(a[30:23]) - 150;
        end
    endfunction

    function automatic logic [31:0] add_square(input logic [31:0] acc, input logic [31:0] x);
        logic [31:0] xa;
        logic [31:0] aa;
        logic [63:0] pm;
        logic [63:0] am;
        int pe;
        int ae;
        int sh;
        xa = {1'b0, x[30:0]};
        aa = {1'b0, acc[30:0]};
        if (xa > PINF_BITS || aa > PINF_BITS) return QNAN_BITS;
        if (xa == PINF_BITS || aa == PINF_BITS) return PINF_BITS;
        split_mag(xa, pm, pe);
        pm = pm * pm;
        pe = 2 * pe;
        split_mag(aa, am, ae);
        if (pm == 0) return aa;
        if (am == 0) return round_pos(pm, pe);
        sh = 61 - top_bit(pm);
        pm = pm << sh;
        pe -= sh;
        sh = 61 - top_bit(am);
        am = am << sh;
        ae -= sh;
        if (pe >= ae) return round_pos(pm + sticky_shift(am, pe - ae), pe);
        return round_pos(am + sticky_shift(pm, ae - pe), ae);
    endfunction

    function automatic logic [31:0] root_of(input logic [31:0] a);
        logic [63:0] m;
        logic [63:0] res;
        logic [63:0] bitv;
        int e;
        int k;
        if (a[30:0] > PINF_BITS) return QNAN_BITS;
        if (a[30:0] == 0) return a;
        if (a[31]) return QNAN_BITS;
        if (a == PINF_BITS) return PINF_BITS;
        split_mag(a, m, e);
        if (e % 2 != 0) begin
            m = m << 1;
            e -= 1;
        end
        k = 61 - top_bit(m);
        if (k % 2 != 0) k--;
        m = m << k;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > m) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (m >= res + bitv) begin
                m = m - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return round_pos((res << 1) | 64'(m != 0), (e - k) / 2 - 1);
    endfunction

    assign o_pending = norm_queue.size();

    always @(posedge i_clk) begin
        logic [31:0] s;
        logic [31:0] want;
        if (!i_rst_n) begin
            acc_sum <= 32'h0;
            o_errors <= 0;
            o_norms <= 0;
            norm_queue.delete();
        end else begin
            s = acc_sum;
            if (i_valid && i_ready_in) begin
                if (i_has_element) s = add_square(s, i_element_bits);
                if (i_last_flag) begin
                    norm_queue.push_back(root_of(s));
                    s = 32'h0;
                end
            end
            acc_sum <= s;
            if (i_out_valid && i_out_ready) begin
                o_norms <= o_norms + 1;
                if (norm_queue.size() == 0) begin
                    $display("%0t: norm transfer with none expected, actual %h",
                             $time, i_norm_bits);
                    o_errors <= o_errors + 1;
                end else begin
                    want = norm_queue.pop_front();
                    if (want !== i_norm_bits) begin
                        $display("%0t: norm_bits expected %h actual %h",
                                 $time, want, i_norm_bits);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives vectors of binary32 elements into the Euclidean norm block with
// random gaps and output stalls; the checker predicts and compares norms.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_element_bits = '0;
    logic        i_has_element = 1'b0;
    logic        i_last_flag = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_norm_bits;
    int          errors;
    int          pending;
    int          norms;
    int          idle_cycles;
    int          sent;
    bit          calm;

    localparam int WATCHDOG = 20000;

    always #2 i_clk = ~i_clk;

    euclidean_norm_float_stream dut (.*);

    norm_checker chk (
        .i_clk, .i_rst_n, .i_valid, .i_ready_in(o_ready), .i_element_bits,
        .i_has_element, .i_last_flag, .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_norm_bits(o_norm_bits), .o_errors(errors), .o_pending(pending),
        .o_norms(norms)
    );

    function automatic logic [31:0] pick_element();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = {1'($urandom_range(0, 1)), 8'hFF, 23'($urandom)};
            1: v = {1'($urandom_range(0, 1)), 8'h00, 23'($urandom)};
            2: v = {1'($urandom_range(0, 1)), 8'($urandom_range(0, 3)), 23'($urandom)};
            3: v = {1'($urandom_range(0, 1)), 8'($urandom_range(180, 254)), 23'($urandom)};
            4: v = $urandom;
            default: v = {1'($urandom_range(0, 1)), 8'($urandom_range(100, 154)),
                          23'($urandom)};
        endcase
        return v;
    endfunction

    task automatic send(input logic [31:0] x, input logic has, input logic last);
        while (!calm && $urandom_range(0, 99) < 6) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_element_bits <= x;
        i_has_element <= has;
        i_last_flag <= last;
        do @(posedge i_clk); while (!o_ready);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    always @(negedge i_clk) i_ready <= calm || ($urandom_range(0, 99) >= 6);

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("timeout at %0t", $time);
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        int len;
        logic [31:0] directed[$];
        sent = 0;
        calm = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // empty vector, then a field-less item followed by an end
        send(32'h0, 1'b0, 1'b1);
        send(32'hFFFF_FFFF, 1'b0, 1'b0);
        send(32'h1234_5678, 1'b0, 1'b1);
        directed = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h007F_FFFF,
                     32'h3F80_0000, 32'hBF80_0000, 32'h7F7F_FFFF, 32'h7F80_0000,
                     32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001,
                     32'h4040_0000, 32'h1F80_0000};
        foreach (directed[j]) send(directed[j], 1'b1, 1'b1);
        send(32'h4040_0000, 1'b1, 1'b0);
        send(32'h4080_0000, 1'b1, 1'b0);
        send(32'h0, 1'b0, 1'b1);
        send(32'h5F80_0000, 1'b1, 1'b0);
        send(32'h5F80_0000, 1'b1, 1'b1);
        drain();
        // random vectors; middle stretch runs with no idling
        while (sent < 1220) begin
            calm = (sent > 500 && sent < 700);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 5);
            for (int j = 0; j < len - 1; j++)
                send(pick_element(), $urandom_range(0, 9) != 0, 1'b0);
            send(pick_element(), $urandom_range(0, 3) != 0, 1'b1);
            if ($urandom_range(0, 40) == 0) drain();
        end
        calm = 1'b0;
        drain();
        repeat (60) @(negedge i_clk);
        $display("covered %0d input items and %0d norms: zeros, subnormals, NaN,", sent, norms);
        $display("infinities, overflowing sums, empty vectors and element-less items");
        if (errors == 0 && pending == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule

// File: euclidean_norm_float_stream.f
+incdir+sv
sv/enf_pkg.sv
sv/enf_ctrl.sv
sv/enf_dp.sv
sv/euclidean_norm_float_stream.sv
sv/enf_checker.sv
tb/norm_checker.sv
tb/tb.sv
